@@ rtl/polynomial_evaluator_unit_defines.svh @@
// Assertion macros for the polynomial evaluator unit.
// Included by the top level; no other dependencies.
`ifndef POLYNOMIAL_EVALUATOR_UNIT_DEFINES_SVH
`define POLYNOMIAL_EVALUATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PEU_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PEU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PEU_ASSERT(lbl, clk, rstn, prop, msg)
`define PEU_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ rtl/polyev_pkg.sv @@
// Shared types and constants of the polynomial evaluator.
// No dependencies.
`default_nettype none

package polyev_pkg;

	localparam int DATA_W      = 32;
	localparam int DEG_W       = 3;
	localparam int CFG_IDX_W   = 4;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int MAX_DEGREE  = 6;
	localparam int FRAC_BITS   = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 4'd1;

	localparam logic signed [PROD_W-1:0] ACC_MAX = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] ACC_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] acc;
		logic                     sat;
	} polyev_item_t;

endpackage

`default_nettype wire

@@ rtl/polyev_step.sv @@
// One Horner step in two register stages: multiply, then shift, add and saturate.
// Depends on polyev_pkg.
`default_nettype none

module polyev_step #(
	parameter int FRAC_BITS = polyev_pkg::FRAC_BITS,
	parameter int COEF_IDX  = 0
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire polyev_pkg::polyev_item_t               in_item,
	input  wire logic signed [polyev_pkg::DATA_W-1:0]   coef,
	input  wire logic [polyev_pkg::DEG_W-1:0]           deg,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output polyev_pkg::polyev_item_t                    out_item
);

	localparam logic [polyev_pkg::DEG_W-1:0] IDX = polyev_pkg::DEG_W'(COEF_IDX);

	logic                                      v_s1;
	logic signed [polyev_pkg::PROD_W-1:0]      prod_s1;
	polyev_pkg::polyev_item_t                  item_s1;
	logic                                      v_s2;
	polyev_pkg::polyev_item_t                  item_s2;

	logic                                      ready_s2;
	logic                                      ready_s1;
	logic signed [polyev_pkg::PROD_W-1:0]      prod;
	logic signed [polyev_pkg::PROD_W-1:0]      sum;
	logic                                      over_hi;
	logic                                      over_lo;
	polyev_pkg::polyev_item_t                  next_item;

	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	assign prod = polyev_pkg::PROD_W'(in_item.acc) * polyev_pkg::PROD_W'(in_item.x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prod_s1 <= prod;
			item_s1 <= in_item;
		end
	end

	assign sum     = (prod_s1 >>> FRAC_BITS) + polyev_pkg::PROD_W'(coef);
	assign over_hi = sum > polyev_pkg::ACC_MAX;
	assign over_lo = sum < polyev_pkg::ACC_MIN;

	always_comb begin
		next_item = item_s1;
		if (deg == IDX) begin
			next_item.acc = coef;
		end else if (deg > IDX) begin
			if (over_hi) begin
				next_item.acc = polyev_pkg::ACC_MAX[polyev_pkg::DATA_W-1:0];
			end else if (over_lo) begin
				next_item.acc = polyev_pkg::ACC_MIN[polyev_pkg::DATA_W-1:0];
			end else begin
				next_item.acc = sum[polyev_pkg::DATA_W-1:0];
			end
			next_item.sat = item_s1.sat | over_hi | over_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			item_s2 <= next_item;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

@@ rtl/polynomial_evaluator_unit.sv @@
// Polynomial evaluator unit: streams x points in, polynomial values out, signed Q16.16.
// One item per cycle unless m_axis_tready holds the pipeline back; each Horner step
// is a 32x32 multiply stage followed by a shift, add and saturate stage, and the steps
// are chained as a pipeline. Steps above the configured degree pass the item through.
// Depends on polyev_pkg, polyev_step and polynomial_evaluator_unit_defines.svh.
`default_nettype none
`include "polynomial_evaluator_unit_defines.svh"

module polynomial_evaluator_unit #(
	parameter int MAX_DEGREE = polyev_pkg::MAX_DEGREE,
	parameter int FRAC_BITS  = polyev_pkg::FRAC_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [polyev_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [polyev_pkg::DATA_W-1:0]        cfg_data,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  wire logic [polyev_pkg::DATA_W-1:0]        s_axis_tdata,  // x_value
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	output logic [polyev_pkg::DATA_W-1:0]             m_axis_tdata,  // poly_value
	output logic                                      m_axis_tuser   // saturated
);

	localparam int NUM_COEFS = MAX_DEGREE + 1;
	localparam int COEF_IW   = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;
	localparam logic [polyev_pkg::DEG_W-1:0] DEG_LIMIT = polyev_pkg::DEG_W'(MAX_DEGREE);
	localparam logic [polyev_pkg::CFG_IDX_W-1:0] COEF_LAST =
		polyev_pkg::REG_COEF0 + polyev_pkg::CFG_IDX_W'(MAX_DEGREE);

	logic [polyev_pkg::DEG_W-1:0]        deg_q;
	logic signed [polyev_pkg::DATA_W-1:0] coef_q [NUM_COEFS];
	logic [polyev_pkg::DEG_W-1:0]        deg_eff;
	logic [polyev_pkg::CFG_IDX_W-1:0]    coef_sel;

	polyev_pkg::polyev_item_t            link_item  [MAX_DEGREE+1];
	logic                                link_valid [MAX_DEGREE+1];
	logic                                link_ready [MAX_DEGREE+1];

	assign cfg_ready = 1'b1;
	assign coef_sel  = cfg_index - polyev_pkg::REG_COEF0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= '0;
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == polyev_pkg::REG_DEGREE) begin
				deg_q <= cfg_data[polyev_pkg::DEG_W-1:0];
			end else if (cfg_index >= polyev_pkg::REG_COEF0 && cfg_index <= COEF_LAST) begin
				coef_q[coef_sel[COEF_IW-1:0]] <= $signed(cfg_data);
			end
		end
	end

	assign deg_eff = (deg_q > DEG_LIMIT) ? DEG_LIMIT : deg_q;

	assign link_valid[0]     = s_axis_tvalid;
	assign s_axis_tready     = link_ready[0];
	assign link_item[0].x    = $signed(s_axis_tdata);
	assign link_item[0].acc  = coef_q[MAX_DEGREE];
	assign link_item[0].sat  = 1'b0;

	for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
		polyev_step #(
			.FRAC_BITS (FRAC_BITS),
			.COEF_IDX  (MAX_DEGREE - 1 - k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_item   (link_item[k]),
			.coef      (coef_q[MAX_DEGREE - 1 - k]),
			.deg       (deg_eff),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_item  (link_item[k+1])
		);

		`PEU_ASSERT(a_link_hold, clk, arst_n, link_valid[k+1] && !link_ready[k+1] |=> link_valid[k+1], "stalled item dropped between steps")
	end

	assign m_axis_tvalid          = link_valid[MAX_DEGREE];
	assign link_ready[MAX_DEGREE] = m_axis_tready;
	assign m_axis_tdata           = link_item[MAX_DEGREE].acc;
	assign m_axis_tuser           = link_item[MAX_DEGREE].sat;

	`PEU_ASSERT(a_empty_out_ready, clk, arst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
	`PEU_ASSERT_NEVER(a_deg_clamp, clk, arst_n, deg_eff > DEG_LIMIT, "degree in use beyond limit")

endmodule

`default_nettype wire
